/* sv/qce_pkg.sv */
// Shared types and constants for the quintic curve evaluator.
`default_nettype none

package qce_pkg;

  // Fixed-point word and lane layout
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PROD_W   = 2 * WORD_W;
  localparam int unsigned COEF_W   = WORD_W + 6;               // room for 60 * a5
  localparam int unsigned SUM_W    = PROD_W - 16 + 1;
  localparam int unsigned LANES    = 4;
  localparam int unsigned NUM_COEF = 6;
  localparam int unsigned STEPS    = NUM_COEF - 1;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned RND_HALF = 32768;

  // Lane order: value, first, second and third derivative
  localparam int unsigned LANE_VAL = 0;
  localparam int unsigned LANE_D1  = 1;
  localparam int unsigned LANE_D2  = 2;
  localparam int unsigned LANE_D3  = 3;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_A0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_A2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_A3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_A4 = 3'd4;
  localparam logic [IDX_W-1:0] REG_A5 = 3'd5;

  // Derivative scale factors
  localparam int unsigned K2  = 2;
  localparam int unsigned K3  = 3;
  localparam int unsigned K4  = 4;
  localparam int unsigned K5  = 5;
  localparam int unsigned K6  = 6;
  localparam int unsigned K12 = 12;
  localparam int unsigned K20 = 20;
  localparam int unsigned K24 = 24;
  localparam int unsigned K60 = 60;

  typedef logic [LANES-1:0][WORD_W-1:0] acc_vec_t;
  typedef logic [LANES-1:0][COEF_W-1:0] coef_vec_t;

  // One word moving along the chain
  typedef struct packed {
    logic [WORD_W-1:0] x;
    acc_vec_t          acc;
    logic              flag;
  } lane_word_t;

endpackage

`default_nettype wire

/* sv/qce_cell.sv */
// One Horner step cell for all four lanes: multiply stage, then round, add and clip.
`default_nettype none

module qce_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               vld_i,
  output logic                    rdy_o,
  input  wire qce_pkg::lane_word_t word_i,
  input  wire qce_pkg::coef_vec_t  coef_i,
  output logic                    vld_o,
  input  wire logic               rdy_i,
  output qce_pkg::lane_word_t     word_o
);
  import qce_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (WORD_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-(64'sd1 <<< (WORD_W - 1)));

  // Stage A: products
  logic                     vld_a_r;
  logic [WORD_W-1:0]        x_a_r;
  logic                     flg_a_r;
  logic signed [PROD_W-1:0] prod_r   [LANES];
  logic signed [PROD_W-1:0] prod_nxt [LANES];

  // Stage B: clipped accumulators
  logic       vld_b_r;
  lane_word_t word_b_r;
  lane_word_t word_b_nxt;

  logic rdy_a;
  logic rdy_b;

  // Stall chain: a stage takes a word when it is empty or its own word moves on
  assign rdy_b = !vld_b_r || rdy_i;
  assign rdy_a = !vld_a_r || rdy_b;
  assign rdy_o = rdy_a;

  // Lane products, exact Q32.32
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod_nxt[l] = $signed(word_i.acc[l]) * $signed(word_i.x);
    end
  end

  // Round to nearest, add coefficient, clip
  always_comb begin
    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0]  sum;
    logic                     clip;
    clip = 1'b0;
    word_b_nxt.x    = x_a_r;
    word_b_nxt.acc  = '0;
    for (int l = 0; l < LANES; l++) begin
      // signed add keeps the shift arithmetic, i.e. a floor
      rnd = (prod_r[l] + $signed(PROD_W'(RND_HALF))) >>> 16;
      sum = SUM_W'($signed(coef_i[l])) + rnd[SUM_W-1:0];
      if (sum > SAT_MAX) begin
        word_b_nxt.acc[l] = SAT_MAX[WORD_W-1:0];
        clip = 1'b1;
      end else if (sum < SAT_MIN) begin
        word_b_nxt.acc[l] = SAT_MIN[WORD_W-1:0];
        clip = 1'b1;
      end else begin
        word_b_nxt.acc[l] = sum[WORD_W-1:0];
      end
    end
    word_b_nxt.flag = flg_a_r | clip;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (rdy_a) vld_a_r <= vld_i;
      if (rdy_b) vld_b_r <= vld_a_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rdy_a && vld_i) begin
      x_a_r   <= word_i.x;
      flg_a_r <= word_i.flag;
      for (int l = 0; l < LANES; l++) begin
        prod_r[l] <= prod_nxt[l];
      end
    end
    if (rdy_b && vld_a_r) begin
      word_b_r <= word_b_nxt;
    end
  end

  assign vld_o  = vld_b_r;
  assign word_o = word_b_r;

  // A held word stays put while downstream stalls
  a_hold_b : assert property (@(posedge clk) disable iff (!rst_n)
    vld_b_r && !rdy_i |=> vld_b_r && $stable(word_b_r))
    else $error("cell output changed while stalled");

  a_hold_a : assert property (@(posedge clk) disable iff (!rst_n)
    vld_a_r && vld_b_r && !rdy_i |=> vld_a_r && $stable(x_a_r) && $stable(flg_a_r))
    else $error("product stage lost a word while stalled");

  a_empty_rdy : assert property (@(posedge clk) disable iff (!rst_n)
    !vld_a_r |-> rdy_o)
    else $error("empty cell refused a word");

  a_flag_keep : assert property (@(posedge clk) disable iff (!rst_n)
    rdy_b && vld_a_r && flg_a_r |=> word_b_r.flag)
    else $error("clip flag dropped");

endmodule

`default_nettype wire

/* sv/quintic_curve_evaluator.sv */
// Quintic curve evaluator: value and three derivatives by a chain of Horner cells.
//
// Usage:
//   Input channel  in_valid/in_ready carries one position word (signed Q16.16).
//   Result channel out_valid/out_ready carries curve_value, the first, second
//   and third derivatives (signed Q16.16, clipped) and the saturated flag.
//   Coefficients a0..a5 are written through cfg_we/cfg_index/cfg_wdata while
//   the block is idle; indexes above five are ignored.
// Timing:
//   Five cells, one per Horner step, each with a multiply register and an
//   accumulate register: a word passes the multiply and accumulate registers
//   of each cell in turn before it shows on the result channel. With out_ready
//   high, one word per cycle is accepted, as every stage of every cell takes a
//   new word in each cycle that its own word moves on.
// Reset:
//   rst_n (synchronous, active low) empties the chain and clears all six
//   coefficients to zero.
// Back-pressure:
//   With out_ready low the last cell holds its word; earlier cells keep
//   filling empty slots, so in_ready drops only once the chain is full.
`default_nettype none

module quintic_curve_evaluator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [qce_pkg::WORD_W-1:0] in_position,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [qce_pkg::WORD_W-1:0]  out_curve_value,
  output logic signed [qce_pkg::WORD_W-1:0]  out_first_derivative,
  output logic signed [qce_pkg::WORD_W-1:0]  out_second_derivative,
  output logic signed [qce_pkg::WORD_W-1:0]  out_third_derivative,
  output logic                               out_saturated,
  input  wire logic                          cfg_we,
  input  wire logic [qce_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [qce_pkg::WORD_W-1:0]    cfg_wdata
);
  import qce_pkg::*;

  function automatic logic signed [COEF_W-1:0] scale(input logic [WORD_W-1:0] c,
                                                     input int unsigned k);
    logic signed [COEF_W-1:0] ce;
    logic signed [COEF_W-1:0] ke;
    ce = COEF_W'($signed(c));
    ke = $signed(COEF_W'(k));
    return ce * ke;
  endfunction

  // Coefficient registers
  logic [WORD_W-1:0] coef_r [NUM_COEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < IDX_W'(NUM_COEF))) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  // Scaled derivative coefficients, formed exactly
  logic signed [COEF_W-1:0] a5x5_r, a4x4_r, a3x3_r, a2x2_r;
  logic signed [COEF_W-1:0] a5x20_r, a4x12_r, a3x6_r;
  logic signed [COEF_W-1:0] a5x60_r, a4x24_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a5x5_r  <= '0;
      a4x4_r  <= '0;
      a3x3_r  <= '0;
      a2x2_r  <= '0;
      a5x20_r <= '0;
      a4x12_r <= '0;
      a3x6_r  <= '0;
      a5x60_r <= '0;
      a4x24_r <= '0;
    end else begin
      a5x5_r  <= scale(coef_r[REG_A5], K5);
      a4x4_r  <= scale(coef_r[REG_A4], K4);
      a3x3_r  <= scale(coef_r[REG_A3], K3);
      a2x2_r  <= scale(coef_r[REG_A2], K2);
      a5x20_r <= scale(coef_r[REG_A5], K20);
      a4x12_r <= scale(coef_r[REG_A4], K12);
      a3x6_r  <= scale(coef_r[REG_A3], K6);
      a5x60_r <= scale(coef_r[REG_A5], K60);
      a4x24_r <= scale(coef_r[REG_A4], K24);
    end
  end

  // Per-step coefficients; shorter lanes run leading zero steps
  coef_vec_t cell_coef [STEPS];

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      cell_coef[k] = '0;
    end
    cell_coef[0][LANE_VAL] = COEF_W'($signed(coef_r[REG_A4]));
    cell_coef[1][LANE_VAL] = COEF_W'($signed(coef_r[REG_A3]));
    cell_coef[2][LANE_VAL] = COEF_W'($signed(coef_r[REG_A2]));
    cell_coef[3][LANE_VAL] = COEF_W'($signed(coef_r[REG_A1]));
    cell_coef[4][LANE_VAL] = COEF_W'($signed(coef_r[REG_A0]));
    cell_coef[0][LANE_D1]  = a5x5_r;
    cell_coef[1][LANE_D1]  = a4x4_r;
    cell_coef[2][LANE_D1]  = a3x3_r;
    cell_coef[3][LANE_D1]  = a2x2_r;
    cell_coef[4][LANE_D1]  = COEF_W'($signed(coef_r[REG_A1]));
    cell_coef[1][LANE_D2]  = a5x20_r;
    cell_coef[2][LANE_D2]  = a4x12_r;
    cell_coef[3][LANE_D2]  = a3x6_r;
    cell_coef[4][LANE_D2]  = a2x2_r;
    cell_coef[2][LANE_D3]  = a5x60_r;
    cell_coef[3][LANE_D3]  = a4x24_r;
    cell_coef[4][LANE_D3]  = a3x6_r;
  end

  // Chain links: link 0 is the input, link STEPS the result
  logic       link_vld [STEPS+1];
  logic       link_rdy [STEPS+1];
  lane_word_t link_word [STEPS+1];

  // Start word: value lane holds a5, derivative lanes start at zero
  always_comb begin
    link_word[0].x             = in_position;
    link_word[0].acc           = '0;
    link_word[0].acc[LANE_VAL] = coef_r[REG_A5];
    link_word[0].flag          = 1'b0;
  end

  assign link_vld[0] = in_valid;
  assign in_ready    = link_rdy[0];

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    qce_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (link_vld[g]),
      .rdy_o  (link_rdy[g]),
      .word_i (link_word[g]),
      .coef_i (cell_coef[g]),
      .vld_o  (link_vld[g+1]),
      .rdy_i  (link_rdy[g+1]),
      .word_o (link_word[g+1])
    );
  end

  assign link_rdy[STEPS] = out_ready;

  // Result word
  assign out_valid             = link_vld[STEPS];
  assign out_curve_value       = $signed(link_word[STEPS].acc[LANE_VAL]);
  assign out_first_derivative  = $signed(link_word[STEPS].acc[LANE_D1]);
  assign out_second_derivative = $signed(link_word[STEPS].acc[LANE_D2]);
  assign out_third_derivative  = $signed(link_word[STEPS].acc[LANE_D3]);
  assign out_saturated         = link_word[STEPS].flag;

endmodule

`default_nettype wire

/* bench/qce_checker.sv */
// Watches both channels of the curve evaluator, predicts each result and compares it.
module qce_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [qce_pkg::WORD_W-1:0]  in_position,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [qce_pkg::WORD_W-1:0]  out_curve_value,
  input  logic signed [qce_pkg::WORD_W-1:0]  out_first_derivative,
  input  logic signed [qce_pkg::WORD_W-1:0]  out_second_derivative,
  input  logic signed [qce_pkg::WORD_W-1:0]  out_third_derivative,
  input  logic                               out_saturated,
  input  logic                               cfg_we,
  input  logic [qce_pkg::IDX_W-1:0]          cfg_index,
  input  logic [qce_pkg::WORD_W-1:0]         cfg_wdata,
  output int                                 fail_count,
  output int                                 pending_words,
  output int                                 clipped_words
);
  timeunit 1ns;
  timeprecision 1ps;
  import qce_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam int     FRAC_W   = 16;

  // One predicted result word
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] d1;
    logic signed [WORD_W-1:0] d2;
    logic signed [WORD_W-1:0] d3;
    logic                     clipped;
  } curve_point_t;

  // Outcome of one Horner chain
  typedef struct packed {
    logic signed [WORD_W-1:0] acc;
    logic                     hit;
  } horner_t;

  logic signed [WORD_W-1:0] coef_reg [NUM_COEF];
  curve_point_t             expected_points [$];
  curve_point_t             head_point;

  initial begin
    fail_count    = 0;
    pending_words = 0;
    clipped_words = 0;
  end

  function automatic longint clip_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // Horner chain over the first n coefficients, highest order first;
  // every step is clipped and later steps carry the clipped value
  function automatic horner_t horner_lane(input longint k0, input longint k1,
                                          input longint k2, input longint k3,
                                          input longint k4, input longint k5,
                                          input int n, input longint x);
    longint  k [NUM_COEF];
    longint  acc;
    longint  sum;
    horner_t r;
    k[0] = k0; k[1] = k1; k[2] = k2;
    k[3] = k3; k[4] = k4; k[5] = k5;
    r.hit = 1'b0;
    acc = clip_word(k[0]);
    if (acc != k[0]) r.hit = 1'b1;
    for (int i = 1; i < n; i++) begin
      // round to nearest, ties upward, back to Q16.16
      sum = k[i] + ((acc * x + longint'(RND_HALF)) >>> FRAC_W);
      acc = clip_word(sum);
      if (acc != sum) r.hit = 1'b1;
    end
    r.acc = acc[WORD_W-1:0];
    return r;
  endfunction

  // Value and three derivatives at one position, from the current coefficients
  function automatic curve_point_t predict_point(input longint x);
    longint       a0, a1, a2, a3, a4, a5;
    horner_t      h0, h1, h2, h3;
    curve_point_t p;
    a0 = coef_reg[REG_A0];
    a1 = coef_reg[REG_A1];
    a2 = coef_reg[REG_A2];
    a3 = coef_reg[REG_A3];
    a4 = coef_reg[REG_A4];
    a5 = coef_reg[REG_A5];
    h0 = horner_lane(a5, a4, a3, a2, a1, a0, NUM_COEF, x);
    h1 = horner_lane(a5 * longint'(K5), a4 * longint'(K4), a3 * longint'(K3),
                     a2 * longint'(K2), a1, 0, NUM_COEF - 1, x);
    h2 = horner_lane(a5 * longint'(K20), a4 * longint'(K12), a3 * longint'(K6),
                     a2 * longint'(K2), 0, 0, NUM_COEF - 2, x);
    h3 = horner_lane(a5 * longint'(K60), a4 * longint'(K24), a3 * longint'(K6),
                     0, 0, 0, NUM_COEF - 3, x);
    p.value   = h0.acc;
    p.d1      = h1.acc;
    p.d2      = h2.acc;
    p.d3      = h3.acc;
    p.clipped = h0.hit | h1.hit | h2.hit | h3.hit;
    return p;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Track configuration, pair each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) coef_reg[i] = '0;
      expected_points.delete();
    end else begin
      if (cfg_we && cfg_index <= REG_A5) coef_reg[cfg_index] = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("result word with no position outstanding");
          fail_count++;
        end else begin
          head_point = expected_points.pop_front();
          check_field("curve_value", head_point.value, out_curve_value);
          check_field("first_derivative", head_point.d1, out_first_derivative);
          check_field("second_derivative", head_point.d2, out_second_derivative);
          check_field("third_derivative", head_point.d3, out_third_derivative);
          check_field("saturated", head_point.clipped, out_saturated);
          if (head_point.clipped) clipped_words++;
        end
      end
      if (in_valid && in_ready) expected_points.push_back(predict_point(in_position));
    end
    pending_words = expected_points.size();
  end

endmodule

/* bench/tb_quintic_curve_evaluator.sv */
// Stimulus and verdict for the quintic curve evaluator, checked by qce_checker.
module tb_quintic_curve_evaluator;
  timeunit 1ns;
  timeprecision 1ps;
  import qce_pkg::*;

  localparam int          RANDOM_PHASES   = 12;
  localparam int          ITEMS_PER_PHASE = 153;
  localparam int          IDLE_MODES      = 4;
  localparam int          COEF_STYLES     = 3;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int          SETTLE_CYCLES   = 20;

  localparam logic [NUM_COEF-1:0][IDX_W-1:0] COEF_REG =
    {REG_A5, REG_A4, REG_A3, REG_A2, REG_A1, REG_A0};
  // indexes past the last coefficient, writes there must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [WORD_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [WORD_W-1:0] Q_HALF = 32'h0000_8000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {COEF_TAME, COEF_WIDE, COEF_MIXED} coef_style_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [WORD_W-1:0]   in_position = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [WORD_W-1:0]   out_curve_value;
  logic signed [WORD_W-1:0]   out_first_derivative;
  logic signed [WORD_W-1:0]   out_second_derivative;
  logic signed [WORD_W-1:0]   out_third_derivative;
  logic                       out_saturated;
  logic                       cfg_we = 1'b0;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [WORD_W-1:0]          cfg_wdata = '0;

  int                         fail_count;
  int                         pending_words;
  int                         clipped_words;
  int                         sender_idle_pct = 0;
  int                         stall_pct = 0;
  int                         positions_sent = 0;
  int                         coef_sets = 0;
  int unsigned                cycle_count = 0;
  logic [NUM_COEF-1:0][WORD_W-1:0] coef_draw;

  quintic_curve_evaluator u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_position           (in_position),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_curve_value       (out_curve_value),
    .out_first_derivative  (out_first_derivative),
    .out_second_derivative (out_second_derivative),
    .out_third_derivative  (out_third_derivative),
    .out_saturated         (out_saturated),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  qce_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_position           (in_position),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_curve_value       (out_curve_value),
    .out_first_derivative  (out_first_derivative),
    .out_second_derivative (out_second_derivative),
    .out_third_derivative  (out_third_derivative),
    .out_saturated         (out_saturated),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .fail_count            (fail_count),
    .pending_words         (pending_words),
    .clipped_words         (clipped_words)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct = 0;
        stall_pct       = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct = 55;
        stall_pct       = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        stall_pct       = 55;
      end
      default: begin
        sender_idle_pct = 6;
        stall_pct       = 6;
      end
    endcase
  endtask

  // Offer one position word and hold it until taken; entered and left at a rising edge
  task automatic push_position(input logic signed [WORD_W-1:0] x);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_position <= x;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    positions_sent++;
  endtask

  // Stop sending and wait for every outstanding result word
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    @(posedge clk);
  endtask

  // Write all six coefficients, then the two spare indexes
  task automatic load_coefs(input logic [NUM_COEF-1:0][WORD_W-1:0] c);
    for (int i = 0; i < NUM_COEF; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= COEF_REG[i];
      cfg_wdata <= c[i];
      @(posedge clk);
    end
    cfg_index <= REG_SPARE_LO;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_index <= REG_SPARE_HI;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    coef_sets++;
  endtask

  function automatic logic [WORD_W-1:0] rand_coef(input coef_style_t style);
    int unsigned pick;
    pick = $urandom_range(99);
    case (style)
      // within +-2.0, keeps results in range for short positions
      COEF_TAME: return int'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      COEF_WIDE: return $urandom;
      default: begin
        if (pick < 30) return $urandom;
        if (pick < 70) return int'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
        if (pick < 80) return '0;
        if (pick < 90) return Q_MAX;
        return Q_MIN;
      end
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_position();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return int'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    if (pick < 60) return int'($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
    if (pick < 85) return $urandom;
    case ($urandom_range(8))
      0: return '0;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return Q_HALF;
      4: return -Q_HALF;
      5: return Q_ONE;
      6: return -Q_ONE;
      7: return Q_MAX;
      default: return Q_MIN;
    endcase
  endfunction

  initial begin
    set_idle(IDLE_NONE);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coefficients straight from reset: all zero
    push_position('0);
    push_position(Q_MAX);
    push_position(Q_MIN);
    drain();

    // One LSB everywhere: rounding ties in both directions
    load_coefs({NUM_COEF{32'h0000_0001}});
    push_position(Q_HALF);
    push_position(-Q_HALF);
    push_position(Q_ONE + Q_HALF);
    push_position(-(Q_ONE + Q_HALF));
    drain();

    // Largest coefficients, then smallest
    load_coefs({NUM_COEF{Q_MAX}});
    push_position(Q_ONE);
    push_position(-Q_ONE);
    push_position(Q_MAX);
    push_position(Q_MIN);
    push_position('0);
    drain();
    load_coefs({NUM_COEF{Q_MIN}});
    push_position(Q_ONE);
    push_position(-Q_ONE);
    push_position(Q_MAX);
    push_position(Q_MIN);
    push_position('0);
    drain();

    // Scaled leading terms clip at once; the plain chain stays in range only for Q_ONE
    load_coefs({Q_MAX, Q_MIN, 32'h0, 32'h0, 32'h0, 32'h0});
    push_position(Q_ONE << 1);
    push_position(-(Q_ONE << 1));
    push_position(Q_ONE);
    drain();

    // Random phases, rotating handshake pattern and coefficient style
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idle(idle_mode_t'(p % IDLE_MODES));
      for (int i = 0; i < NUM_COEF; i++)
        coef_draw[i] = rand_coef(coef_style_t'(p % COEF_STYLES));
      load_coefs(coef_draw);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_position(rand_position());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d positions over %0d coefficient sets, four handshake patterns",
             positions_sent, coef_sets);
    $display("%0d result words carried a clipping flag", clipped_words);
    if (fail_count == 0 && pending_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* quintic_curve_evaluator.f */
sv/qce_pkg.sv
sv/qce_cell.sv
sv/quintic_curve_evaluator.sv
bench/qce_checker.sv
bench/tb_quintic_curve_evaluator.sv
